FILE: rtl/lrn_pkg.sv
`timescale 1ns / 1ps
package lrn_pkg;

  localparam int RES_W = 24;
  localparam int INDEX_BITS_DEF = 63;
  localparam int PROD_W = 2 * RES_W;
  localparam int RED_W = RES_W + 2;
  localparam int QUO_W = RES_W + 1;
  localparam int FIFO_DEPTH = 2;

  localparam logic [RES_W-1:0] TERM_MOD = RES_W'(10000007);
  localparam logic [RED_W-1:0] TERM_MOD2 = RED_W'(2 * 10000007);
  // floor(2^48 / modulus), Barrett constant
  localparam logic [QUO_W-1:0] BARRETT_MU = QUO_W'((64'd1 << PROD_W) / 64'd10000007);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_NEXT,
    ST_RUN,
    ST_COPY
  } lrn_state_e;

  typedef enum logic [1:0] {
    OP_MULACC,
    OP_SQR,
    OP_FIN
  } lrn_op_e;

  typedef struct packed {
    logic             special;
    logic [RES_W-1:0] x;
    logic [RES_W-1:0] y;
    logic [RES_W-1:0] z;
    logic [RES_W-1:0] q;
    logic [RES_W-1:0] r;
    logic [RES_W-1:0] s;
  } lrn_item_t;

  typedef struct packed {
    logic       first_k;
    logic       last_k;
    logic       last_entry;
    logic [3:0] entry;
  } lrn_tag_t;

  function automatic logic [3:0] idx3(input logic [1:0] row, input logic [1:0] col);
    idx3 = 4'(row) * 4'd3 + 4'(col);
  endfunction

  function automatic logic [RES_W-1:0] reduce_once(input logic [RES_W-1:0] v);
    reduce_once = (v >= TERM_MOD) ? v - TERM_MOD : v;
  endfunction

endpackage

FILE: rtl/lrn_front.sv
`timescale 1ns / 1ps
module lrn_front #(
  parameter int INDEX_BITS = lrn_pkg::INDEX_BITS_DEF
) (
  input  logic [INDEX_BITS-1:0]   term_index_i,
  input  logic [lrn_pkg::RES_W-1:0] coef_one_i,
  input  logic [lrn_pkg::RES_W-1:0] coef_two_i,
  input  logic [lrn_pkg::RES_W-1:0] coef_three_i,
  input  logic [lrn_pkg::RES_W-1:0] first_term_i,
  input  logic [lrn_pkg::RES_W-1:0] second_term_i,
  input  logic [lrn_pkg::RES_W-1:0] third_term_i,
  output lrn_pkg::lrn_item_t      item_o,
  output logic [INDEX_BITS-1:0]   exp_o
);

  logic [lrn_pkg::RES_W-1:0] q_red, r_red, s_red;

  assign q_red = lrn_pkg::reduce_once(first_term_i);
  assign r_red = lrn_pkg::reduce_once(second_term_i);
  assign s_red = lrn_pkg::reduce_once(third_term_i);

  always_comb begin
    item_o.x = lrn_pkg::reduce_once(coef_one_i);
    item_o.y = lrn_pkg::reduce_once(coef_two_i);
    item_o.z = lrn_pkg::reduce_once(coef_three_i);
    item_o.q = q_red;
    item_o.r = r_red;
    item_o.special = (term_index_i <= INDEX_BITS'(3));
    // special items carry their answer in s
    unique case (term_index_i[1:0])
      2'd1:    item_o.s = item_o.special ? q_red : s_red;
      2'd2:    item_o.s = item_o.special ? r_red : s_red;
      2'd3:    item_o.s = s_red;
      default: item_o.s = item_o.special ? '0 : s_red;
    endcase
    exp_o = term_index_i - INDEX_BITS'(3);
  end

endmodule

FILE: rtl/lrn_fifo.sv
`timescale 1ns / 1ps
module lrn_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = lrn_pkg::FIFO_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DEPTH-1:0][WIDTH-1:0] mem_q;
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PW:0]   cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == (PW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + (PW+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

FILE: rtl/lrn_mulmod.sv
`timescale 1ns / 1ps
module lrn_mulmod (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic [lrn_pkg::RES_W-1:0] a_i,
  input  logic [lrn_pkg::RES_W-1:0] b_i,
  input  lrn_pkg::lrn_tag_t       tag_i,
  output logic                    valid_o,
  output logic [lrn_pkg::RES_W-1:0] res_o,
  output lrn_pkg::lrn_tag_t       tag_o
);

  localparam int PW = lrn_pkg::PROD_W;
  localparam int RW = lrn_pkg::RED_W;
  localparam int QW = lrn_pkg::QUO_W;

  logic [3:0] v_q;
  lrn_pkg::lrn_tag_t tag1_q, tag2_q, tag3_q, tag4_q;
  logic [PW-1:0]   p1_q, p2_q;
  logic [RW-1:0]   p3_q;
  logic [2*QW-1:0] t2_q;
  logic [RW-1:0]   qm3_q;
  logic [lrn_pkg::RES_W-1:0] r4_q;
  logic [RW-1:0]   r0;
  logic [QW-1:0]   q_est;
  logic [QW+lrn_pkg::RES_W-1:0] qm_full;

  assign q_est   = t2_q[2*QW-1:QW];
  assign qm_full = q_est * lrn_pkg::TERM_MOD;
  assign r0      = p3_q - qm3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    p1_q   <= a_i * b_i;
    tag1_q <= tag_i;
    t2_q   <= p1_q[PW-1:PW-QW] * lrn_pkg::BARRETT_MU;
    p2_q   <= p1_q;
    tag2_q <= tag1_q;
    qm3_q  <= qm_full[RW-1:0];
    p3_q   <= p2_q[RW-1:0];
    tag3_q <= tag2_q;
    // Barrett estimate is short by at most two
    if (r0 >= lrn_pkg::TERM_MOD2) begin
      r4_q <= lrn_pkg::RES_W'(r0 - lrn_pkg::TERM_MOD2);
    end else if (r0 >= RW'(lrn_pkg::TERM_MOD)) begin
      r4_q <= lrn_pkg::RES_W'(r0 - RW'(lrn_pkg::TERM_MOD));
    end else begin
      r4_q <= lrn_pkg::RES_W'(r0);
    end
    tag4_q <= tag3_q;
  end

  assign valid_o = v_q[3];
  assign res_o   = r4_q;
  assign tag_o   = tag4_q;

endmodule

FILE: rtl/lrn_back.sv
`timescale 1ns / 1ps
module lrn_back #(
  parameter int INDEX_BITS = lrn_pkg::INDEX_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    fifo_empty_i,
  input  lrn_pkg::lrn_item_t      item_i,
  input  logic [INDEX_BITS-1:0]   exp_i,
  output logic                    fifo_pop_o,
  output logic                    res_valid_o,
  output logic [lrn_pkg::RES_W-1:0] res_o,
  input  logic                    res_pop_i
);

  localparam int W = lrn_pkg::RES_W;

  lrn_pkg::lrn_state_e state_q, state_d;
  lrn_pkg::lrn_op_e    op_q;
  logic [INDEX_BITS-1:0] n_q;
  logic                  did_q;
  logic [1:0]            i_q, j_q, k_q;
  logic                  iss_done_q;
  logic [8:0][W-1:0]     acc_q, base_q, tmp_q;
  logic [2:0][W-1:0]     vec_q;
  logic [W-1:0]          run_q;
  logic                  res_valid_q;
  logic [W-1:0]          res_q;

  logic                  take;
  logic                  issue;
  logic [W-1:0]          opa, opb;
  lrn_pkg::lrn_tag_t     tag_in, tag_out;
  logic                  mm_valid;
  logic [W-1:0]          mm_res;
  logic [W:0]            sum_raw;
  logic [W-1:0]          sum_red;
  logic                  n_high_zero;
  logic                  run_end;

  assign n_high_zero = (n_q[INDEX_BITS-1:1] == '0);
  assign run_end     = mm_valid && tag_out.last_k && tag_out.last_entry;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lrn_pkg::ST_IDLE: begin
        if (take && !item_i.special) begin
          state_d = lrn_pkg::ST_NEXT;
        end
      end
      lrn_pkg::ST_NEXT: begin
        if (!(n_high_zero && n_q[0] && did_q)) begin
          state_d = lrn_pkg::ST_RUN;
        end
      end
      lrn_pkg::ST_RUN: begin
        if (run_end) begin
          state_d = (op_q == lrn_pkg::OP_FIN) ? lrn_pkg::ST_IDLE : lrn_pkg::ST_COPY;
        end
      end
      lrn_pkg::ST_COPY: state_d = lrn_pkg::ST_NEXT;
      default:          state_d = lrn_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    take   = (state_q == lrn_pkg::ST_IDLE) && !fifo_empty_i && !res_valid_q;
    issue  = (state_q == lrn_pkg::ST_RUN) && !iss_done_q;
    opa    = (op_q == lrn_pkg::OP_SQR) ? base_q[lrn_pkg::idx3(i_q, k_q)]
                                       : acc_q[lrn_pkg::idx3(i_q, k_q)];
    opb    = (op_q == lrn_pkg::OP_FIN) ? vec_q[k_q] : base_q[lrn_pkg::idx3(k_q, j_q)];
    tag_in.first_k    = (k_q == 2'd0);
    tag_in.last_k     = (k_q == 2'd2);
    tag_in.last_entry = (op_q == lrn_pkg::OP_FIN) || (i_q == 2'd2 && j_q == 2'd2);
    tag_in.entry      = lrn_pkg::idx3(i_q, j_q);
  end

  assign fifo_pop_o = take;

  lrn_mulmod u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (issue),
    .a_i     (opa),
    .b_i     (opb),
    .tag_i   (tag_in),
    .valid_o (mm_valid),
    .res_o   (mm_res),
    .tag_o   (tag_out)
  );

  assign sum_raw = (tag_out.first_k ? (W+1)'(0) : (W+1)'(run_q)) + (W+1)'(mm_res);
  assign sum_red = (sum_raw >= (W+1)'(lrn_pkg::TERM_MOD))
                 ? W'(sum_raw - (W+1)'(lrn_pkg::TERM_MOD)) : W'(sum_raw);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lrn_pkg::ST_IDLE;
      op_q        <= lrn_pkg::OP_FIN;
      res_valid_q <= 1'b0;
      iss_done_q  <= 1'b0;
      did_q       <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
    end else begin
      state_q <= state_d;
      if (res_valid_q && res_pop_i) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        lrn_pkg::ST_IDLE: begin
          did_q <= 1'b0;
          if (take && item_i.special) begin
            res_valid_q <= 1'b1;
          end
        end
        lrn_pkg::ST_NEXT: begin
          i_q        <= '0;
          j_q        <= '0;
          k_q        <= '0;
          iss_done_q <= 1'b0;
          if (n_q == '0) begin
            op_q <= lrn_pkg::OP_FIN;
          end else if (n_q[0] && !did_q) begin
            op_q  <= lrn_pkg::OP_MULACC;
            did_q <= 1'b1;
          end else if (!n_high_zero) begin
            op_q  <= lrn_pkg::OP_SQR;
            did_q <= 1'b0;
          end else begin
            did_q <= 1'b0;
          end
        end
        lrn_pkg::ST_RUN: begin
          if (issue) begin
            if (k_q != 2'd2) begin
              k_q <= k_q + 2'd1;
            end else begin
              k_q <= '0;
              if (op_q == lrn_pkg::OP_FIN || (i_q == 2'd2 && j_q == 2'd2)) begin
                iss_done_q <= 1'b1;
              end else if (j_q != 2'd2) begin
                j_q <= j_q + 2'd1;
              end else begin
                j_q <= '0;
                i_q <= i_q + 2'd1;
              end
            end
          end
          if (run_end && op_q == lrn_pkg::OP_FIN) begin
            res_valid_q <= 1'b1;
          end
        end
        lrn_pkg::ST_COPY: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q     <= item_i.s;
      n_q       <= exp_i;
      // identity
      acc_q     <= {W'(1), {3{W'(0)}}, W'(1), {3{W'(0)}}, W'(1)};
      // companion matrix
      base_q    <= {W'(0), W'(1), {3{W'(0)}}, W'(1), item_i.z, item_i.y, item_i.x};
      vec_q[0]  <= item_i.s;
      vec_q[1]  <= item_i.r;
      vec_q[2]  <= item_i.q;
    end
    if (state_q == lrn_pkg::ST_NEXT) begin
      if (n_q != '0 && !(n_q[0] && !did_q)) begin
        n_q <= n_q >> 1;
      end
    end
    if (mm_valid) begin
      run_q <= sum_red;
      if (tag_out.last_k) begin
        tmp_q[tag_out.entry] <= sum_red;
      end
      if (run_end && op_q == lrn_pkg::OP_FIN) begin
        res_q <= sum_red;
      end
    end
    if (state_q == lrn_pkg::ST_COPY) begin
      if (op_q == lrn_pkg::OP_MULACC) begin
        acc_q <= tmp_q;
      end else begin
        base_q <= tmp_q;
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

FILE: rtl/linear_recurrence_nth_term.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake           Payload
// query     in         push / full         term_index_i, coef_*_i, *_term_i
// result    out        empty / pop         term_value_o
//
// Indexes 0..3 are answered straight from the query. Larger indexes take
// one modular 3x3 product (27 issues into the shared 4-stage mod multiplier)
// per set bit of m-3 and per bit below its top set bit, plus a 3-issue final
// step. No clearing pass after reset.
// A two-item queue lets queries be pushed while the back end works or a
// result waits for pop.
module linear_recurrence_nth_term #(
  parameter int INDEX_BITS = lrn_pkg::INDEX_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push,
  output logic                    full,
  input  logic [INDEX_BITS-1:0]   term_index_i,
  input  logic [lrn_pkg::RES_W-1:0] coef_one_i,
  input  logic [lrn_pkg::RES_W-1:0] coef_two_i,
  input  logic [lrn_pkg::RES_W-1:0] coef_three_i,
  input  logic [lrn_pkg::RES_W-1:0] first_term_i,
  input  logic [lrn_pkg::RES_W-1:0] second_term_i,
  input  logic [lrn_pkg::RES_W-1:0] third_term_i,
  output logic                    empty,
  input  logic                    pop,
  output logic [lrn_pkg::RES_W-1:0] term_value_o
);

  localparam int IW = $bits(lrn_pkg::lrn_item_t);
  localparam int FW = INDEX_BITS + IW;

  lrn_pkg::lrn_item_t    fe_item, be_item;
  logic [INDEX_BITS-1:0] fe_exp, be_exp;
  logic [FW-1:0]         q_out;
  logic                  q_empty, q_pop, res_valid;

  lrn_front #(.INDEX_BITS(INDEX_BITS)) u_front (
    .term_index_i  (term_index_i),
    .coef_one_i    (coef_one_i),
    .coef_two_i    (coef_two_i),
    .coef_three_i  (coef_three_i),
    .first_term_i  (first_term_i),
    .second_term_i (second_term_i),
    .third_term_i  (third_term_i),
    .item_o        (fe_item),
    .exp_o         (fe_exp)
  );

  lrn_fifo #(.WIDTH(FW), .DEPTH(lrn_pkg::FIFO_DEPTH)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({fe_exp, fe_item}),
    .full_o  (full),
    .pop_i   (q_pop),
    .data_o  (q_out),
    .empty_o (q_empty)
  );

  assign be_exp  = q_out[FW-1:IW];
  assign be_item = q_out[IW-1:0];

  lrn_back #(.INDEX_BITS(INDEX_BITS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_empty_i (q_empty),
    .item_i       (be_item),
    .exp_i        (be_exp),
    .fifo_pop_o   (q_pop),
    .res_valid_o  (res_valid),
    .res_o        (term_value_o),
    .res_pop_i    (pop)
  );

  assign empty = !res_valid;

  a_res_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> term_value_o < lrn_pkg::TERM_MOD) else $error("result out of range");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty) else $error("queue popped while empty");

  a_pop_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> empty) else $error("item taken while result pending");

  a_res_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty) else $error("result dropped without pop");

endmodule

FILE: sim/linear_recurrence_nth_term_tb.sv
`timescale 1ns / 1ps
module linear_recurrence_nth_term_tb;

  localparam int IDX_W = lrn_pkg::INDEX_BITS_DEF;
  localparam int RW = lrn_pkg::RES_W;
  localparam longint unsigned MODULUS = 64'd10000007;
  localparam int RANDOM_ITEMS = 1150;
  localparam int QUIET_ITEMS = 150;

  typedef longint unsigned mat3_t[3][3];

  class term_scoreboard;
    logic [RW-1:0] expected_terms[$];

    static function automatic longint unsigned mulmod(longint unsigned a, longint unsigned b);
      return (a * b) % MODULUS;
    endfunction

    static function automatic void mat_mul(input mat3_t a, input mat3_t b, output mat3_t p);
      longint unsigned acc;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          acc = 0;
          for (int k = 0; k < 3; k++) acc += mulmod(a[i][k], b[k][j]);
          p[i][j] = acc % MODULUS;
        end
      end
    endfunction

    static function automatic logic [RW-1:0] nth_term(logic [IDX_W-1:0] m,
        logic [RW-1:0] cx, logic [RW-1:0] cy, logic [RW-1:0] cz,
        logic [RW-1:0] tq, logic [RW-1:0] tr, logic [RW-1:0] ts);
      longint unsigned x, y, z, q, r, s, n, v;
      mat3_t acc, base, tmp;
      x = cx % MODULUS; y = cy % MODULUS; z = cz % MODULUS;
      q = tq % MODULUS; r = tr % MODULUS; s = ts % MODULUS;
      if (m == 0) return '0;
      if (m == 1) return RW'(q);
      if (m == 2) return RW'(r);
      if (m == 3) return RW'(s);
      n = 64'(m) - 3;
      acc = '{'{1, 0, 0}, '{0, 1, 0}, '{0, 0, 1}};
      base = '{'{x, y, z}, '{1, 0, 0}, '{0, 1, 0}};
      for (int b = 0; b < 64; b++) begin
        if (n[b]) begin
          mat_mul(acc, base, tmp);
          acc = tmp;
        end
        mat_mul(base, base, tmp);
        base = tmp;
      end
      v = (mulmod(acc[0][0], s) + mulmod(acc[0][1], r) + mulmod(acc[0][2], q)) % MODULUS;
      return RW'(v);
    endfunction

    function void note_query(logic [IDX_W-1:0] m, logic [RW-1:0] cx, logic [RW-1:0] cy,
        logic [RW-1:0] cz, logic [RW-1:0] tq, logic [RW-1:0] tr, logic [RW-1:0] ts);
      expected_terms.push_back(nth_term(m, cx, cy, cz, tq, tr, ts));
    endfunction

    // 0: ok, 1: nothing waiting, 2: wrong value
    function int check_term(logic [RW-1:0] got, output logic [RW-1:0] want);
      want = '0;
      if (expected_terms.size() == 0) return 1;
      want = expected_terms.pop_front();
      return (got === want) ? 0 : 2;
    endfunction

    function int pending();
      return expected_terms.size();
    endfunction
  endclass

  logic clk_i, rst_ni, push, full, empty, pop;
  logic [IDX_W-1:0] term_index_i;
  logic [RW-1:0] coef_one_i, coef_two_i, coef_three_i;
  logic [RW-1:0] first_term_i, second_term_i, third_term_i;
  logic [RW-1:0] term_value_o;

  term_scoreboard sb;
  int errors = 0;
  bit quiet = 0;

  linear_recurrence_nth_term uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full),
    .term_index_i(term_index_i), .coef_one_i(coef_one_i), .coef_two_i(coef_two_i),
    .coef_three_i(coef_three_i), .first_term_i(first_term_i),
    .second_term_i(second_term_i), .third_term_i(third_term_i),
    .empty(empty), .pop(pop), .term_value_o(term_value_o)
  );

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #40ms;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic report(string what, logic [RW-1:0] got, logic [RW-1:0] want);
    $display("mismatch @%0t: %s got %0d want %0d", $time, what, got, want);
    errors++;
  endtask

  task automatic send_query(logic [IDX_W-1:0] m, logic [RW-1:0] cx, logic [RW-1:0] cy,
      logic [RW-1:0] cz, logic [RW-1:0] tq, logic [RW-1:0] tr, logic [RW-1:0] ts);
    int gap;
    term_index_i <= m;
    coef_one_i <= cx; coef_two_i <= cy; coef_three_i <= cz;
    first_term_i <= tq; second_term_i <= tr; third_term_i <= ts;
    push <= 1'b1;
    do @(posedge clk_i); while (full);
    sb.note_query(m, cx, cy, cz, tq, tr, ts);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 9);
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic logic [RW-1:0] rand_field();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return RW'(MODULUS - 1);
      2: return RW'($urandom_range(10000007, 24'hFFFFFF));
      3: return RW'($urandom_range(0, 3));
      default: return RW'($urandom_range(0, 10000006));
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] rand_index();
    logic [IDX_W-1:0] v;
    int nb;
    v = IDX_W'({$urandom, $urandom});
    case ($urandom_range(0, 19))
      0: nb = IDX_W;
      1, 2: nb = $urandom_range(9, 32);
      3, 4, 5: nb = 2;
      default: nb = $urandom_range(3, 8);
    endcase
    if (nb < IDX_W) v &= (IDX_W'(1) << nb) - IDX_W'(1);
    return v;
  endfunction

  task automatic drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // receive side
  initial begin
    int hold;
    int rc;
    logic [RW-1:0] want;
    hold = 0;
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        rc = sb.check_term(term_value_o, want);
        if (rc == 1) report("unexpected item", term_value_o, want);
        else if (rc == 2) report("term_value", term_value_o, want);
      end
      if (hold > 0) begin
        hold--;
        pop <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(0, 8);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    logic [RW-1:0] mx;
    sb = new();
    mx = RW'(MODULUS - 1);
    rst_ni = 1'b0;
    push = 1'b0;
    term_index_i = '0;
    coef_one_i = '0; coef_two_i = '0; coef_three_i = '0;
    first_term_i = '0; second_term_i = '0; third_term_i = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_query(0, 5, 6, 7, 11, 12, 13);
    send_query(1, 5, 6, 7, 11, 12, 13);
    send_query(2, 5, 6, 7, 11, 12, 13);
    send_query(3, 5, 6, 7, 11, 12, 13);
    send_query(4, 1, 1, 1, 1, 1, 1);
    send_query(5, 2, 3, 4, 1, 2, 3);
    send_query(20, 1, 1, 0, 0, 1, 1);
    send_query(10, 0, 0, 0, 7, 8, 9);
    send_query(10, mx, mx, mx, mx, mx, mx);
    send_query(1, '1, '1, '1, '1, '1, '1);
    send_query(3, '1, '1, '1, '1, '1, '1);
    send_query(7, '1, '1, '1, '1, '1, '1);
    send_query(6, 24'd10000007, 24'd10000007, 24'd10000007, 24'd10000007,
               24'd10000007, 24'd10000007);
    send_query({IDX_W{1'b1}}, 3, 5, 7, 1, 2, 3);
    send_query({1'b1, {(IDX_W-1){1'b0}}}, mx, 1, mx, mx, 0, 1);
    send_query(100, 0, 0, 1, 4, 5, 6);
    drain();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) drain();
      if (i == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1;
      send_query(rand_index(), rand_field(), rand_field(), rand_field(),
                 rand_field(), rand_field(), rand_field());
    end
    drain();
    repeat (50) @(posedge clk_i);

    if (errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
